// ===== rtl/sps_pkg.sv =====
// Shared types and constants of the servo pose sequencer.
`timescale 1ns / 1ps

package sps_pkg;

   localparam int POSE_DEPTH = 12;
   localparam int POSE_IDX_W = $clog2(POSE_DEPTH);
   localparam int JOINTS = 3;

   localparam logic [7:0] ANGLE_LIMIT = 8'd181;
   localparam logic [7:0] CODE_STOP = 8'hC8;
   localparam logic [7:0] CODE_READBACK = 8'hCA;
   localparam logic [4:0] FULL_SPEED = 5'd20;

   localparam logic [7:0] RESET_ANGLE_TOP = 8'd90;
   localparam logic [7:0] RESET_ANGLE_MIDDLE = 8'd155;
   localparam logic [7:0] RESET_ANGLE_BOTTOM = 8'd2;

   localparam logic OP_CONTROL = 1'b0;
   localparam logic OP_BUS_READ = 1'b1;

   localparam int QUOT_W = 5;
   localparam int REM_W = 13;

   typedef struct packed {
      logic       opcode;
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       servos_idle;
      logic [7:0] pos_top;
      logic [7:0] pos_middle;
      logic [7:0] pos_bottom;
   } req_type;

   typedef struct packed {
      logic       move_valid;
      logic       hold_valid;
      logic [7:0] target_top;
      logic [7:0] target_middle;
      logic [7:0] target_bottom;
      logic [4:0] speed_top;
      logic [4:0] speed_middle;
      logic [4:0] speed_bottom;
      logic       irq_level;
      logic       read_valid;
      logic [7:0] read_data;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_FETCH_LAST,
      ST_PEAK,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_HOLD,
      KIND_MOVE,
      KIND_READ
   } kind_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       rd_issue;
      logic [1:0] rd_lane;
      logic       cap_valid;
      logic [1:0] cap_lane;
      logic       peak;
      logic       div_step;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic is_move;
      logic div_last;
      logic slot_free;
   } status_type;

endpackage

// ===== rtl/sps_stream_if.sv =====
// Valid/ready stream interface carrying one request or response payload.
`timescale 1ns / 1ps

interface sps_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sps_ctrl.sv =====
// Controller state machine sequencing decode, pose fetch, division and publish.
`timescale 1ns / 1ps

module sps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sps_pkg::status_type  status,
   output sps_pkg::cmd_type     cmd
);
   import sps_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = status.is_move ? ST_FETCH0 : ST_PUBLISH;
         end
         ST_FETCH0: state_in = ST_FETCH1;
         ST_FETCH1: state_in = ST_FETCH2;
         ST_FETCH2: state_in = ST_FETCH_LAST;
         ST_FETCH_LAST: state_in = ST_PEAK;
         ST_PEAK: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: cmd.decode = 1'b1;
         ST_FETCH0: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_lane = 2'd0;
         end
         ST_FETCH1: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_lane = 2'd1;
            cmd.cap_valid = 1'b1;
            cmd.cap_lane = 2'd0;
         end
         ST_FETCH2: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_lane = 2'd2;
            cmd.cap_valid = 1'b1;
            cmd.cap_lane = 2'd1;
         end
         ST_FETCH_LAST: begin
            cmd.cap_valid = 1'b1;
            cmd.cap_lane = 2'd2;
         end
         ST_PEAK: cmd.peak = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_PUBLISH: cmd.publish = status.slot_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/sps_datapath.sv =====
// Datapath: command decode, pose store, sequencing state, speed divider, response register.
`timescale 1ns / 1ps

module sps_datapath #(
   parameter int NUM_SUBMOVES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  sps_pkg::cmd_type    cmd,
   output sps_pkg::status_type status,
   input  sps_pkg::req_type    req_payload,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output sps_pkg::rsp_type    rsp_payload
);
   import sps_pkg::*;

   localparam int SC_W = $clog2(NUM_SUBMOVES + 2);
   localparam logic [SC_W-1:0] SC_LAST = SC_W'(NUM_SUBMOVES);
   localparam logic [POSE_IDX_W-1:0] BASE_LAST = POSE_IDX_W'(POSE_DEPTH - JOINTS);
   localparam logic [POSE_IDX_W-1:0] RINDEX_FULL = POSE_IDX_W'(POSE_DEPTH);

   logic [7:0] pose_mem [POSE_DEPTH];
   logic [7:0] rdata_ff;

   req_type                item_ff, item_in;
   logic [7:0]             last_ff [JOINTS];
   logic [7:0]             last_in [JOINTS];
   logic [7:0]             capt_ff [JOINTS];
   logic [7:0]             capt_in [JOINTS];
   logic [7:0]             tgt_ff [JOINTS];
   logic [7:0]             tgt_in [JOINTS];
   logic [7:0]             delta_ff [JOINTS];
   logic [7:0]             delta_in [JOINTS];
   logic [REM_W-1:0]       rem_ff [JOINTS];
   logic [REM_W-1:0]       rem_in [JOINTS];
   logic [QUOT_W-1:0]      quot_ff [JOINTS];
   logic [QUOT_W-1:0]      quot_in [JOINTS];
   logic [REM_W-1:0]       divisor_ff, divisor_in;
   logic [2:0]             step_ff, step_in;
   logic [POSE_IDX_W-1:0]  rindex_ff, rindex_in;
   logic [POSE_IDX_W-1:0]  base_ff, base_in;
   logic [SC_W-1:0]        subseq_ff, subseq_in;
   logic                   start_ff, start_in;
   logic                   running_ff, running_in;
   logic                   stop_ff, stop_in;
   logic                   armed_ff, armed_in;
   logic [1:0]             cursor_ff, cursor_in;
   logic                   irq_ff, irq_in;
   kind_type               kind_ff, kind_in;
   logic [7:0]             rdbyte_ff, rdbyte_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   byte_angle;
   logic                   wrap;
   logic                   start_eff;
   logic [SC_W-1:0]        subseq_eff;
   logic [POSE_IDX_W-1:0]  base_eff;
   logic                   stop_eff;
   logic                   armed_eff;
   logic                   irq_eff;
   logic                   is_move;
   logic [7:0]             pos [JOINTS];
   logic [7:0]             peak;
   logic [POSE_IDX_W-1:0]  rd_addr;
   logic [7:0]             capt_sel;

   assign pos[0] = item_ff.pos_top;
   assign pos[1] = item_ff.pos_middle;
   assign pos[2] = item_ff.pos_bottom;

   assign byte_angle = item_ff.byte_valid && (item_ff.data_byte >= 8'd1)
                       && (item_ff.data_byte <= ANGLE_LIMIT);
   assign wrap = byte_angle && ((rindex_ff + 1'b1) == RINDEX_FULL);
   assign start_eff = wrap || start_ff;
   assign subseq_eff = wrap ? '0 : subseq_ff;
   assign base_eff = wrap ? '0 : base_ff;
   assign stop_eff = stop_ff || (item_ff.byte_valid && item_ff.data_byte == CODE_STOP);
   assign armed_eff = armed_ff
                      || (item_ff.byte_valid && item_ff.data_byte == CODE_READBACK);
   assign irq_eff = byte_angle ? 1'b0 : irq_ff;
   assign is_move = (item_ff.opcode == OP_CONTROL) && !stop_eff && start_eff
                    && (subseq_eff < SC_LAST);

   assign peak = (delta_ff[0] >= delta_ff[1])
                 ? ((delta_ff[0] >= delta_ff[2]) ? delta_ff[0] : delta_ff[2])
                 : ((delta_ff[1] >= delta_ff[2]) ? delta_ff[1] : delta_ff[2]);

   assign rd_addr = base_ff + {{(POSE_IDX_W-2){1'b0}}, cmd.rd_lane};

   always_comb begin
      capt_sel = '0;
      for (int k = 0; k < JOINTS; k++) begin
         if (cursor_ff == 2'(k)) capt_sel = capt_ff[k];
      end
   end

   assign status.is_move = is_move;
   assign status.div_last = (step_ff == 3'(QUOT_W - 1));
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.decode && item_ff.opcode == OP_CONTROL && byte_angle) begin
         pose_mem[rindex_ff] <= item_ff.data_byte - 8'd1;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= pose_mem[rd_addr];
      end
   end

   always_comb begin
      item_in = item_ff;
      for (int k = 0; k < JOINTS; k++) begin
         last_in[k] = last_ff[k];
         capt_in[k] = capt_ff[k];
         tgt_in[k] = tgt_ff[k];
         delta_in[k] = delta_ff[k];
         rem_in[k] = rem_ff[k];
         quot_in[k] = quot_ff[k];
      end
      divisor_in = divisor_ff;
      step_in = step_ff;
      rindex_in = rindex_ff;
      base_in = base_ff;
      subseq_in = subseq_ff;
      start_in = start_ff;
      running_in = running_ff;
      stop_in = stop_ff;
      armed_in = armed_ff;
      cursor_in = cursor_ff;
      irq_in = irq_ff;
      kind_in = kind_ff;
      rdbyte_in = rdbyte_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.capture) item_in = req_payload;

      if (cmd.decode) begin
         if (item_ff.opcode == OP_BUS_READ) begin
            kind_in = KIND_NONE;
            if (armed_ff) begin
               kind_in = KIND_READ;
               rdbyte_in = capt_sel;
               if (cursor_ff == 2'd2) begin
                  cursor_in = '0;
                  armed_in = 1'b0;
               end else begin
                  cursor_in = cursor_ff + 2'd1;
               end
            end
         end else begin
            rindex_in = wrap ? '0 : (byte_angle ? rindex_ff + 1'b1 : rindex_ff);
            start_in = start_eff;
            subseq_in = subseq_eff;
            base_in = base_eff;
            stop_in = stop_eff;
            armed_in = armed_eff;
            irq_in = irq_eff;
            kind_in = KIND_NONE;
            if (stop_eff) begin
               stop_in = 1'b0;
               running_in = 1'b0;
               start_in = 1'b0;
               armed_in = 1'b1;
               kind_in = KIND_HOLD;
               for (int k = 0; k < JOINTS; k++) begin
                  capt_in[k] = pos[k];
                  last_in[k] = pos[k] + 8'd1;
                  tgt_in[k] = pos[k];
               end
            end else if (is_move) begin
               start_in = 1'b0;
               running_in = 1'b1;
               kind_in = KIND_MOVE;
            end else if (running_ff && item_ff.servos_idle) begin
               start_in = 1'b1;
               subseq_in = subseq_eff + 1'b1;
               running_in = 1'b0;
               base_in = (base_eff == BASE_LAST) ? '0 : base_eff + POSE_IDX_W'(JOINTS);
            end else if (subseq_eff == SC_LAST) begin
               irq_in = 1'b1;
               start_in = 1'b0;
               subseq_in = subseq_eff + 1'b1;
            end
         end
      end

      if (cmd.cap_valid) begin
         for (int k = 0; k < JOINTS; k++) begin
            if (cmd.cap_lane == 2'(k)) begin
               delta_in[k] = (rdata_ff > last_ff[k]) ? rdata_ff - last_ff[k]
                                                     : last_ff[k] - rdata_ff;
               last_in[k] = rdata_ff;
               tgt_in[k] = rdata_ff;
            end
         end
      end

      if (cmd.peak) begin
         divisor_in = {1'b0, peak, 4'b0000};
         step_in = '0;
         for (int k = 0; k < JOINTS; k++) begin
            rem_in[k] = ({5'b0, delta_ff[k]} << 4) + ({5'b0, delta_ff[k]} << 2);
            quot_in[k] = '0;
         end
      end

      if (cmd.div_step) begin
         divisor_in = divisor_ff >> 1;
         step_in = step_ff + 3'd1;
         for (int k = 0; k < JOINTS; k++) begin
            if (divisor_ff != '0 && rem_ff[k] >= divisor_ff) begin
               rem_in[k] = rem_ff[k] - divisor_ff;
               quot_in[k] = {quot_ff[k][QUOT_W-2:0], 1'b1};
            end else begin
               quot_in[k] = {quot_ff[k][QUOT_W-2:0], 1'b0};
            end
         end
      end

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.move_valid = (kind_ff == KIND_MOVE);
         rsp_in.hold_valid = (kind_ff == KIND_HOLD);
         if (kind_ff == KIND_MOVE || kind_ff == KIND_HOLD) begin
            rsp_in.target_top = tgt_ff[0];
            rsp_in.target_middle = tgt_ff[1];
            rsp_in.target_bottom = tgt_ff[2];
         end
         if (kind_ff == KIND_MOVE) begin
            rsp_in.speed_top = quot_ff[0];
            rsp_in.speed_middle = quot_ff[1];
            rsp_in.speed_bottom = quot_ff[2];
         end
         rsp_in.irq_level = irq_ff;
         rsp_in.read_valid = (kind_ff == KIND_READ);
         rsp_in.read_data = (kind_ff == KIND_READ) ? rdbyte_ff : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      for (int k = 0; k < JOINTS; k++) begin
         tgt_ff[k] <= tgt_in[k];
         delta_ff[k] <= delta_in[k];
         rem_ff[k] <= rem_in[k];
         quot_ff[k] <= quot_in[k];
      end
      divisor_ff <= divisor_in;
      step_ff <= step_in;
      kind_ff <= kind_in;
      rdbyte_ff <= rdbyte_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         last_ff[0] <= RESET_ANGLE_TOP;
         last_ff[1] <= RESET_ANGLE_MIDDLE;
         last_ff[2] <= RESET_ANGLE_BOTTOM;
         for (int k = 0; k < JOINTS; k++) begin
            capt_ff[k] <= '0;
         end
         rindex_ff <= '0;
         base_ff <= '0;
         subseq_ff <= '0;
         start_ff <= 1'b0;
         running_ff <= 1'b0;
         stop_ff <= 1'b0;
         armed_ff <= 1'b0;
         cursor_ff <= '0;
         irq_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < JOINTS; k++) begin
            last_ff[k] <= last_in[k];
            capt_ff[k] <= capt_in[k];
         end
         rindex_ff <= rindex_in;
         base_ff <= base_in;
         subseq_ff <= subseq_in;
         start_ff <= start_in;
         running_ff <= running_in;
         stop_ff <= stop_in;
         armed_ff <= armed_in;
         cursor_ff <= cursor_in;
         irq_ff <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/servo_pose_sequencer.sv =====
// Top level of the three-joint servo pose sequencer.
`timescale 1ns / 1ps

// Takes one request at a time and answers each with exactly one response.
// A bus read, or a control step that issues no sub-move, goes from acceptance
// to the response register through accept, decode and publish; a control
// step that issues a sub-move also passes three reads of the single-port
// pose store and the 5-step shared speed divider. The next request
// is taken in the cycle after the response is loaded, while that response still
// waits for the sink.
module servo_pose_sequencer #(
   parameter int NUM_SUBMOVES = 4
) (
   input logic        clock,
   input logic        reset,
   sps_stream_if.sink   req_bus,
   sps_stream_if.source rsp_bus
);
   import sps_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready_w;
   logic       rsp_valid_w;
   rsp_type    rsp_payload_w;

   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready_w),
      .status    (status),
      .cmd       (cmd)
   );

   sps_datapath #(.NUM_SUBMOVES(NUM_SUBMOVES)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_bus.payload),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid_w),
      .rsp_payload (rsp_payload_w)
   );

   assign req_bus.ready = ready_w;
   assign rsp_bus.valid = rsp_valid_w;
   assign rsp_bus.payload = rsp_payload_w;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a request is in flight");

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_bus.valid)
      else $error("published response not presented");

   a_one_motion_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.payload.move_valid && rsp_bus.payload.hold_valid))
      else $error("move and hold in one response");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.payload.move_valid) |->
         (rsp_bus.payload.speed_top <= FULL_SPEED
          && rsp_bus.payload.speed_middle <= FULL_SPEED
          && rsp_bus.payload.speed_bottom <= FULL_SPEED))
      else $error("speed out of range");

endmodule
